// ===== rtl/core/xsp_pkg.sv =====
// xsp_pkg: shared types, constants and helper functions for the xor/sha-1 password encoder
// no dependencies; compiled first
package xsp_pkg;

  localparam int DIGEST_BYTES = 20;
  localparam int BYTE_CNT_W   = 5;
  localparam logic [BYTE_CNT_W-1:0] LAST_BYTE_IDX = BYTE_CNT_W'(DIGEST_BYTES - 1);

  localparam int MSG_W        = 8 * DIGEST_BYTES;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ROUND_W      = 7;
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(79);

  // at most 24 characters: six groups of three digest bytes
  localparam int MAX_CHARS    = 24;
  localparam int GROUPS       = MAX_CHARS / 4;
  localparam int STREAM_W     = 6 * MAX_CHARS;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam logic [31:0] LEN_WORD = 32'(MSG_W);

  typedef logic [MSG_W-1:0] msg_t;

  typedef struct packed {
    logic valid;
    msg_t msg;
  } q_push_t;

  typedef struct packed {
    logic valid;
    msg_t msg;
  } q_head_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_FINAL,
    BK_EMIT
  } back_state_t;

  function automatic logic [31:0] sha_k(input logic [ROUND_W-1:0] rnd);
    if (rnd < ROUND_W'(20))      sha_k = 32'h5A827999;
    else if (rnd < ROUND_W'(40)) sha_k = 32'h6ED9EBA1;
    else if (rnd < ROUND_W'(60)) sha_k = 32'h8F1BBCDC;
    else                         sha_k = 32'hCA62C1D6;
  endfunction

  // 6-bit code to ascii; the two top codes reuse '0' and '1'
  function automatic logic [6:0] code_to_ascii(input logic [5:0] c);
    if (c < 6'd26)      code_to_ascii = 7'h41 + 7'(c);
    else if (c < 6'd52) code_to_ascii = 7'h61 + 7'(c - 6'd26);
    else if (c < 6'd62) code_to_ascii = 7'h30 + 7'(c - 6'd52);
    else if (c == 6'd62) code_to_ascii = 7'h30;
    else                code_to_ascii = 7'h31;
  endfunction

endpackage

// ===== rtl/core/xsp_if.sv =====
// xsp_in_if / xsp_out_if: valid/ready channel bundles for the encoder
// no dependencies
interface xsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] target_byte;
  logic [7:0] master_byte;

  modport source (output valid, target_byte, master_byte, input ready);
  modport sink   (input valid, target_byte, master_byte, output ready);
endinterface

interface xsp_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

// ===== rtl/core/xor_sha1_password_encoder_core.sv =====
// xor_sha1_password_encoder_core: top level, xor-mix front end, message queue, sha-1 back end
// depends on xsp_pkg, xsp_if, xsp_front, xsp_fifo, xsp_back
//
//   channel  dir  beat payload                         handshake
//   in_ch    in   target_byte[7:0], master_byte[7:0]   valid/ready
//   out_ch   out  char_code[6:0], last_char            valid/ready
//
// a run is 20 input beats; it yields OUTPUT_CHARS characters, at most 24, the last one marked
// back end steps per run: load, 80 rounds, digest add, then the character emit, which holds
// while out_ch is not ready; all rounds go through the single shared sha-1 round unit
// input beats go at one per cycle; the queue holds two finished messages, so the front
// end only stalls on the closing beat of a run while the queue is full
// reset is synchronous, active low, and clears all control state
module xor_sha1_password_encoder_core #(
  parameter int OUTPUT_CHARS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  xsp_in_if.sink     in_ch,
  xsp_out_if.source  out_ch
);

  xsp_pkg::q_push_t q_push;
  xsp_pkg::q_head_t q_head;
  logic             q_pop;
  logic             q_full;

  xsp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push)
  );

  xsp_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_full (q_full)
  );

  xsp_back #(
    .OUTPUT_CHARS (OUTPUT_CHARS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/core/xsp_front.sv =====
// xsp_front: takes byte pairs, xors them and assembles the 20-byte message
// depends on xsp_pkg, xsp_if
module xsp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  xsp_in_if.sink                in_ch,
  input  logic                  q_full,
  output xsp_pkg::q_push_t      q_push
);

  localparam int HOLD_W = xsp_pkg::MSG_W - 8;

  logic [xsp_pkg::BYTE_CNT_W-1:0] count_r, count_nxt;
  logic [HOLD_W-1:0]              msg_r, msg_nxt;
  logic [7:0]                     mixed;
  logic                           accept;
  logic                           at_last;

  assign mixed   = in_ch.target_byte ^ in_ch.master_byte;
  assign at_last = (count_r == xsp_pkg::LAST_BYTE_IDX);
  // only the closing beat of a run needs room in the queue
  assign in_ch.ready = !at_last || !q_full;
  assign accept  = in_ch.valid && in_ch.ready;

  assign q_push.valid = accept && at_last;
  assign q_push.msg   = {msg_r, mixed};

  always_comb begin
    count_nxt = count_r;
    msg_nxt   = msg_r;
    if (accept) begin
      msg_nxt   = {msg_r[HOLD_W-9:0], mixed};
      count_nxt = at_last ? '0 : count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r <= msg_nxt;
  end

endmodule

// ===== rtl/core/xsp_fifo.sv =====
// xsp_fifo: short message queue between the byte front end and the hash back end
// depends on xsp_pkg
module xsp_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  xsp_pkg::q_push_t      q_push,
  input  logic                  q_pop,
  output xsp_pkg::q_head_t      q_head,
  output logic                  q_full
);

  xsp_pkg::msg_t               mem [xsp_pkg::QUEUE_DEPTH];
  logic [xsp_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [xsp_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [xsp_pkg::QCNT_W-1:0]  count_r, count_nxt;
  logic                        do_push, do_pop;

  assign q_full       = (count_r == xsp_pkg::QCNT_W'(xsp_pkg::QUEUE_DEPTH));
  assign q_head.valid = (count_r != '0);
  assign q_head.msg   = mem[rd_ptr_r];

  assign do_push = q_push.valid && !q_full;
  assign do_pop  = q_pop && q_head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == xsp_pkg::QPTR_W'(xsp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == xsp_pkg::QPTR_W'(xsp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= q_push.msg;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> !q_full)
    else $error("message pushed into a full queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= xsp_pkg::QCNT_W'(xsp_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/core/xsp_back.sv =====
// xsp_back: sha-1 over one padded block, one round per cycle, then 6-bit char emit
// depends on xsp_pkg, xsp_if
module xsp_back #(
  parameter int OUTPUT_CHARS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  xsp_pkg::q_head_t      q_head,
  output logic                  q_pop,
  xsp_out_if.source             out_ch
);

  localparam int NCHARS = (OUTPUT_CHARS > xsp_pkg::MAX_CHARS) ? xsp_pkg::MAX_CHARS
                                                               : OUTPUT_CHARS;
  localparam int IDX_W  = (NCHARS > 1) ? $clog2(NCHARS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NCHARS - 1);

  xsp_pkg::back_state_t state_r, state_nxt;
  logic [xsp_pkg::ROUND_W-1:0] round_r, round_nxt;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] pre_r, pre_nxt;
  logic [31:0] win_r [16];
  logic [31:0] win_nxt [16];
  logic [xsp_pkg::STREAM_W-1:0] stream_r, stream_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [6:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  logic [31:0] f_val, t_val, w_new, k_next;
  logic [xsp_pkg::ROUND_W-1:0] round_inc;
  logic [xsp_pkg::MSG_W-1:0] digest;
  logic        emit_load;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.last_char = out_last_r;

  assign round_inc = round_r + 1'b1;
  assign k_next    = xsp_pkg::sha_k(round_inc);
  assign emit_load = (state_r == xsp_pkg::BK_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    if (round_r < xsp_pkg::ROUND_W'(20)) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
    end else if (round_r < xsp_pkg::ROUND_W'(40)) begin
      f_val = b_r ^ c_r ^ d_r;
    end else if (round_r < xsp_pkg::ROUND_W'(60)) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    end else begin
      f_val = b_r ^ c_r ^ d_r;
    end
  end

  // pre_r already holds e + k + w for this round
  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + pre_r;

  always_comb begin
    logic [31:0] x;
    x     = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    w_new = {x[30:0], x[31]};
  end

  // final chaining words, big-endian digest
  assign digest = {xsp_pkg::IV0 + a_r, xsp_pkg::IV1 + b_r, xsp_pkg::IV2 + c_r,
                   xsp_pkg::IV3 + d_r, xsp_pkg::IV4 + e_r};

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    pre_nxt       = pre_r;
    stream_nxt    = stream_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    for (int i = 0; i < 16; i++) begin
      win_nxt[i] = win_r[i];
    end

    unique case (state_r)
      xsp_pkg::BK_IDLE: begin
        if (q_head.valid) begin
          q_pop = 1'b1;
          for (int i = 0; i < 5; i++) begin
            win_nxt[i] = q_head.msg[xsp_pkg::MSG_W-1-32*i -: 32];
          end
          win_nxt[5] = xsp_pkg::PAD_WORD;
          for (int i = 6; i < 15; i++) begin
            win_nxt[i] = '0;
          end
          win_nxt[15] = xsp_pkg::LEN_WORD;
          a_nxt     = xsp_pkg::IV0;
          b_nxt     = xsp_pkg::IV1;
          c_nxt     = xsp_pkg::IV2;
          d_nxt     = xsp_pkg::IV3;
          e_nxt     = xsp_pkg::IV4;
          pre_nxt   = xsp_pkg::IV4 + xsp_pkg::sha_k('0)
                      + q_head.msg[xsp_pkg::MSG_W-1 -: 32];
          round_nxt = '0;
          state_nxt = xsp_pkg::BK_ROUND;
        end
      end
      xsp_pkg::BK_ROUND: begin
        a_nxt = t_val;
        b_nxt = a_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        d_nxt = c_r;
        e_nxt = d_r;
        // next round's e is this d, its word is win[1] after the shift
        pre_nxt = d_r + k_next + win_r[1];
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[15] = w_new;
        round_nxt   = round_inc;
        if (round_r == xsp_pkg::LAST_ROUND) begin
          round_nxt = '0;
          state_nxt = xsp_pkg::BK_FINAL;
        end
      end
      xsp_pkg::BK_FINAL: begin
        // each group of three bytes packed little-endian, codes taken low first
        for (int g = 0; g < xsp_pkg::GROUPS; g++) begin
          stream_nxt[24*g +: 24] = {digest[xsp_pkg::MSG_W-1-8*(3*g+2) -: 8],
                                    digest[xsp_pkg::MSG_W-1-8*(3*g+1) -: 8],
                                    digest[xsp_pkg::MSG_W-1-8*(3*g) -: 8]};
        end
        idx_nxt   = '0;
        state_nxt = xsp_pkg::BK_EMIT;
      end
      xsp_pkg::BK_EMIT: begin
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = xsp_pkg::code_to_ascii(stream_r[5:0]);
          out_last_nxt  = (idx_r == LAST_IDX);
          stream_nxt    = {6'd0, stream_r[xsp_pkg::STREAM_W-1:6]};
          idx_nxt       = idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            state_nxt = xsp_pkg::BK_IDLE;
          end
        end
      end
      default: state_nxt = xsp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xsp_pkg::BK_IDLE;
      round_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    e_r        <= e_nxt;
    pre_r      <= pre_nxt;
    stream_r   <= stream_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    for (int i = 0; i < 16; i++) begin
      win_r[i] <= win_nxt[i];
    end
  end

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == xsp_pkg::BK_ROUND |-> round_r <= xsp_pkg::LAST_ROUND)
    else $error("round counter past the last round");

  a_rounds_to_final: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == xsp_pkg::BK_ROUND && round_r == xsp_pkg::LAST_ROUND
    |=> state_r == xsp_pkg::BK_FINAL)
    else $error("last round did not lead to the digest step");

  a_last_char_closes: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load && idx_r == LAST_IDX
    |=> state_r == xsp_pkg::BK_IDLE && out_valid_r && out_last_r)
    else $error("final character not marked or run not closed");

endmodule
